>>> hw/rtl/tts_pkg.sv
// tts_pkg: shared types, codes and constants of the periodic task tick scheduler
// no dependencies; compile first

package tts_pkg;

  localparam int SlotCountDefault = 8;
  localparam int MaxOut           = 8;
  localparam int FireCntW         = $clog2(MaxOut + 1);

  // command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_CREATE  = 3'd1;
  localparam logic [2:0] CMD_DELETE  = 3'd2;
  localparam logic [2:0] CMD_SUSPEND = 3'd3;
  localparam logic [2:0] CMD_RESUME  = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_USED     = 2'd2;
  localparam logic [1:0] ST_NO_TASK  = 2'd3;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FIRE   = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMD,
    S_TICK,
    S_FLUSH
  } state_t;

  typedef struct packed {
    logic [7:0] period;
    logic [7:0] countdown;
  } entry_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [2:0] fired_slot;
    logic       last;
  } result_t;

endpackage

>>> hw/rtl/tts_if.sv
// tts_cmd_if, tts_res_if: valid/ready channels for commands and results
// no dependencies

interface tts_cmd_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] slot;
  logic [7:0] period;
  logic [7:0] first_delay;

  modport source (output valid, command, slot, period, first_delay, input ready);
  modport sink   (input valid, command, slot, period, first_delay, output ready);
endinterface

interface tts_res_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [1:0] status;
  logic [2:0] fired_slot;
  logic       last;

  modport source (output valid, kind, status, fired_slot, last, input ready);
  modport sink   (input valid, kind, status, fired_slot, last, output ready);
endinterface

>>> hw/rtl/tts_slot_mem.sv
// tts_slot_mem: per-slot period and countdown storage, one write and one read port
// depends on tts_pkg; read data registered

module tts_slot_mem
  import tts_pkg::*;
#(
  parameter int DEPTH = SlotCountDefault,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata
);

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hw/rtl/tts_seq.sv
// tts_seq: command handling and tick walk over the slot memory
// depends on tts_pkg, tts_if; drives tts_slot_mem and the result register in the top level

module tts_seq
  import tts_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault,
  parameter int IdxW       = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1
) (
  input  logic            clk,
  input  logic            rst,
  tts_cmd_if.sink         cmd,
  input  logic            out_free,
  output logic            push,
  output result_t         push_res,
  output logic            mem_we,
  output logic [IdxW-1:0] mem_waddr,
  output entry_t          mem_wdata,
  output logic            mem_re,
  output logic [IdxW-1:0] mem_raddr,
  input  entry_t          mem_rdata
);

  localparam int CntW = $clog2(SLOT_COUNT + 1);

  state_t                state, state_next;
  logic [CntW-1:0]       idx, idx_next;
  logic                  s1_valid, s1_valid_next;
  logic [IdxW-1:0]       s1_idx, s1_idx_next;
  logic                  pend_valid, pend_valid_next;
  logic [2:0]            pend_slot, pend_slot_next;
  logic [FireCntW-1:0]   fire_cnt, fire_cnt_next;
  logic [SLOT_COUNT-1:0] valid_vec, valid_vec_next;
  logic [SLOT_COUNT-1:0] running_vec, running_vec_next;

  logic [2:0] req_cmd;
  logic [3:0] req_slot;
  logic [7:0] req_period;
  logic [7:0] req_delay;

  logic            req_in_range;
  logic [IdxW-1:0] req_idx;
  logic            issue;
  logic            s1_on;
  logic            s1_due;
  logic            report;
  logic            need_push;
  logic            stall;
  logic [3:0]      slot_ext;

  assign cmd.ready    = (state == S_IDLE);
  assign req_in_range = ({1'b0, req_slot} < 5'(SLOT_COUNT));
  assign req_idx      = req_slot[IdxW-1:0];
  assign issue        = (idx < CntW'(SLOT_COUNT));
  assign s1_on        = valid_vec[s1_idx] && running_vec[s1_idx];
  assign s1_due       = (mem_rdata.countdown == 8'd0);
  assign report       = s1_valid && s1_on && s1_due && (fire_cnt < FireCntW'(MaxOut));
  // a new fire can only be held once the previous one has gone out
  assign need_push    = report && pend_valid;
  assign stall        = need_push && !out_free;
  assign slot_ext     = 4'(s1_idx);

  always_comb begin
    state_next       = state;
    idx_next         = idx;
    s1_valid_next    = s1_valid;
    s1_idx_next      = s1_idx;
    pend_valid_next  = pend_valid;
    pend_slot_next   = pend_slot;
    fire_cnt_next    = fire_cnt;
    valid_vec_next   = valid_vec;
    running_vec_next = running_vec;
    push             = 1'b0;
    push_res         = '0;
    mem_we           = 1'b0;
    mem_waddr        = s1_idx;
    mem_wdata.period    = mem_rdata.period;
    mem_wdata.countdown = s1_due ? mem_rdata.period : (mem_rdata.countdown - 8'd1);
    mem_re           = 1'b0;
    mem_raddr        = idx[IdxW-1:0];

    unique case (state)
      S_IDLE: begin
        if (cmd.valid) begin
          if (cmd.command == CMD_TICK) begin
            state_next      = S_TICK;
            idx_next        = '0;
            s1_valid_next   = 1'b0;
            pend_valid_next = 1'b0;
            fire_cnt_next   = '0;
          end else if (cmd.command <= CMD_RESUME) begin
            state_next = S_CMD;
          end
        end
      end

      S_CMD: begin
        if (out_free) begin
          push            = 1'b1;
          push_res.kind   = KIND_STATUS;
          push_res.last   = 1'b1;
          push_res.status = ST_OK;
          state_next      = S_IDLE;
          priority if (!req_in_range) begin
            push_res.status = ST_BAD_SLOT;
          end else if (req_cmd == CMD_CREATE) begin
            if (valid_vec[req_idx]) begin
              push_res.status = ST_USED;
            end else begin
              valid_vec_next[req_idx] = 1'b1;
              mem_we              = 1'b1;
              mem_waddr           = req_idx;
              mem_wdata.period    = req_period;
              mem_wdata.countdown = req_delay;
            end
          end else if (!valid_vec[req_idx]) begin
            push_res.status = ST_NO_TASK;
          end else if (req_cmd == CMD_DELETE) begin
            // stored period and countdown are dead once the valid mark drops
            valid_vec_next[req_idx]   = 1'b0;
            running_vec_next[req_idx] = 1'b1;
          end else if (req_cmd == CMD_SUSPEND) begin
            running_vec_next[req_idx] = 1'b0;
          end else begin
            running_vec_next[req_idx] = 1'b1;
          end
        end
      end

      S_TICK: begin
        if (!stall) begin
          mem_re        = issue;
          s1_valid_next = issue;
          s1_idx_next   = idx[IdxW-1:0];
          if (issue) begin
            idx_next = idx + CntW'(1);
          end
          if (s1_valid && s1_on) begin
            mem_we = 1'b1;
          end
          if (report) begin
            pend_valid_next = 1'b1;
            pend_slot_next  = slot_ext[2:0];
            fire_cnt_next   = fire_cnt + FireCntW'(1);
          end
          if (need_push) begin
            push                = 1'b1;
            push_res.kind       = KIND_FIRE;
            push_res.status     = ST_OK;
            push_res.fired_slot = pend_slot;
            push_res.last       = 1'b0;
          end
          if (!issue && !s1_valid) begin
            state_next = S_FLUSH;
          end
        end
      end

      S_FLUSH: begin
        if (!pend_valid) begin
          state_next = S_IDLE;
        end else if (out_free) begin
          push                = 1'b1;
          push_res.kind       = KIND_FIRE;
          push_res.status     = ST_OK;
          push_res.fired_slot = pend_slot;
          push_res.last       = 1'b1;
          pend_valid_next     = 1'b0;
          state_next          = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      idx         <= '0;
      s1_valid    <= 1'b0;
      pend_valid  <= 1'b0;
      fire_cnt    <= '0;
      valid_vec   <= '0;
      running_vec <= '1;
    end else begin
      state       <= state_next;
      idx         <= idx_next;
      s1_valid    <= s1_valid_next;
      pend_valid  <= pend_valid_next;
      fire_cnt    <= fire_cnt_next;
      valid_vec   <= valid_vec_next;
      running_vec <= running_vec_next;
    end
  end

  always_ff @(posedge clk) begin
    s1_idx    <= s1_idx_next;
    pend_slot <= pend_slot_next;
    if (cmd.valid && cmd.ready) begin
      req_cmd    <= cmd.command;
      req_slot   <= cmd.slot;
      req_period <= cmd.period;
      req_delay  <= cmd.first_delay;
    end
  end

  a_no_push_idle: assert property (@(posedge clk) disable iff (rst)
    !(push && state == S_IDLE))
    else $error("result pushed while idle");

  a_fire_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    fire_cnt <= FireCntW'(MaxOut))
    else $error("fire count above limit");

  a_pend_counted: assert property (@(posedge clk) disable iff (rst)
    pend_valid |-> (fire_cnt != '0))
    else $error("held fire without count");

  a_flush_drained: assert property (@(posedge clk) disable iff (rst)
    (state == S_FLUSH) |-> !s1_valid)
    else $error("flush with slot still in flight");

  a_nonlast_in_tick: assert property (@(posedge clk) disable iff (rst)
    (push && !push_res.last) |-> (state == S_TICK && push_res.kind == KIND_FIRE))
    else $error("non-final result outside tick walk");

endmodule

>>> hw/rtl/periodic_task_tick_scheduler.sv
// A command is registered, then its status result enters the result register when
// that is free. One command in flight; none is taken until its result is pushed.
// Tick: one slot per cycle through the single read port of the slot memory unless the
// result side holds back. Results leave through a registered output stage.
// Reset (synchronous): valid marks cleared, running marks set, walk state cleared.
// Slot memory is not cleared; create writes an entry before its data is ever used.

module periodic_task_tick_scheduler
  import tts_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input logic      clk,
  input logic      rst,
  tts_cmd_if.sink  cmd,
  tts_res_if.source res
);

  localparam int IdxW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  logic            out_free;
  logic            push;
  result_t         push_res;
  result_t         res_q;
  logic            mem_we;
  logic [IdxW-1:0] mem_waddr;
  entry_t          mem_wdata;
  logic            mem_re;
  logic [IdxW-1:0] mem_raddr;
  entry_t          mem_rdata;

  tts_seq #(
    .SLOT_COUNT (SLOT_COUNT),
    .IdxW       (IdxW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .out_free  (out_free),
    .push      (push),
    .push_res  (push_res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  tts_slot_mem #(
    .DEPTH (SLOT_COUNT),
    .AW    (IdxW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result register frees up in the same cycle its transaction completes
  assign out_free = !res.valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (out_free) begin
      res.valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && push) begin
      res_q <= push_res;
    end
  end

  assign res.kind       = res_q.kind;
  assign res.status     = res_q.status;
  assign res.fired_slot = res_q.fired_slot;
  assign res.last       = res_q.last;

endmodule

>>> verif/tts_result_checker.sv
`timescale 1ns / 1ps
// tts_result_checker: watches the command and result channels of the tick scheduler,
// predicts status and fire results and compares them in order
// depends on tts_pkg and tts_if

module tts_result_checker
  import tts_pkg::*;
#(
  parameter int SLOT_COUNT = SlotCountDefault
) (
  input  logic        clk,
  input  logic        rst,
  tts_cmd_if          cmd_mon,
  tts_res_if          res_mon,
  output int unsigned errors,
  output int unsigned pending
);

  logic       task_valid     [16];
  logic       task_running   [16];
  logic [7:0] task_period    [16];
  logic [7:0] task_countdown [16];

  result_t     expected_results [$];
  int unsigned mismatch_count;

  assign errors = mismatch_count;

  task automatic clear_task(input int idx);
    task_valid[idx]     = 1'b0;
    task_running[idx]   = 1'b1;
    task_period[idx]    = 8'd0;
    task_countdown[idx] = 8'd0;
  endtask

  task automatic predict_command(input logic [2:0] command, input logic [3:0] slot,
                                 input logic [7:0] period, input logic [7:0] first_delay);
    int         due_slots [$];
    logic [1:0] st;
    result_t    r;
    if (command == CMD_TICK) begin
      // walk in priority order; due tasks reload, the rest count down
      for (int i = 0; i < SLOT_COUNT; i++) begin
        if (task_valid[i] && task_running[i]) begin
          if (task_countdown[i] == 8'd0) begin
            if (due_slots.size() < MaxOut) due_slots.push_back(i);
            task_countdown[i] = task_period[i];
          end else begin
            task_countdown[i] = task_countdown[i] - 8'd1;
          end
        end
      end
      foreach (due_slots[k]) begin
        r.kind       = KIND_FIRE;
        r.status     = ST_OK;
        r.fired_slot = 3'(due_slots[k]);
        r.last       = (k == due_slots.size() - 1);
        expected_results.push_back(r);
      end
    end else if (command <= CMD_RESUME) begin
      if (int'(slot) >= SLOT_COUNT) begin
        st = ST_BAD_SLOT;
      end else if (command == CMD_CREATE) begin
        if (task_valid[slot]) begin
          st = ST_USED;
        end else begin
          task_valid[slot]     = 1'b1;
          task_period[slot]    = period;
          task_countdown[slot] = first_delay;
          st = ST_OK;
        end
      end else if (!task_valid[slot]) begin
        st = ST_NO_TASK;
      end else begin
        if (command == CMD_DELETE) clear_task(int'(slot));
        else if (command == CMD_SUSPEND) task_running[slot] = 1'b0;
        else task_running[slot] = 1'b1;
        st = ST_OK;
      end
      r.kind       = KIND_STATUS;
      r.status     = st;
      r.fired_slot = 3'd0;
      r.last       = 1'b1;
      expected_results.push_back(r);
    end
  endtask

  task automatic check_result();
    result_t want;
    result_t got;
    got.kind       = res_mon.kind;
    got.status     = res_mon.status;
    got.fired_slot = res_mon.fired_slot;
    got.last       = res_mon.last;
    if (expected_results.size() == 0) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: unexpected result kind=%0d status=%0d fired_slot=%0d last=%0d",
                 $realtime, got.kind, got.status, got.fired_slot, got.last);
    end else begin
      want = expected_results.pop_front();
      if (want.kind != got.kind || want.status != got.status ||
          want.fired_slot != got.fired_slot || want.last != got.last) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: kind/status/fired_slot/last expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                   $realtime, want.kind, want.status, want.fired_slot, want.last,
                   got.kind, got.status, got.fired_slot, got.last);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) clear_task(i);
      expected_results.delete();
    end else begin
      if (res_mon.valid && res_mon.ready) check_result();
      if (cmd_mon.valid && cmd_mon.ready)
        predict_command(cmd_mon.command, cmd_mon.slot, cmd_mon.period, cmd_mon.first_delay);
    end
    pending <= expected_results.size();
  end

endmodule

>>> verif/tb_periodic_task_tick_scheduler.sv
`timescale 1ns / 1ps
// tb_periodic_task_tick_scheduler: drives commands and ticks into the scheduler with
// random idling on both channels; checking is done by tts_result_checker
// depends on tts_pkg, tts_if, the scheduler rtl and verif/tts_result_checker.sv

module tb_periodic_task_tick_scheduler;
  import tts_pkg::*;

  localparam int SLOTS = SlotCountDefault;

  logic        clk = 1'b0;
  logic        rst;
  int unsigned failures;
  int unsigned outstanding;
  int unsigned commands_sent;
  bit          hold_off_done;
  bit          quiet;

  tts_cmd_if cmd_ch ();
  tts_res_if res_ch ();

  always #5 clk = ~clk;

  periodic_task_tick_scheduler #(.SLOT_COUNT(SLOTS)) dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  tts_result_checker #(.SLOT_COUNT(SLOTS)) result_check (
    .clk     (clk),
    .rst     (rst),
    .cmd_mon (cmd_ch),
    .res_mon (res_ch),
    .errors  (failures),
    .pending (outstanding)
  );

  // mostly short gaps, a few long ones, none while quiet
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic send_item(input logic [2:0] c, input logic [3:0] s,
                           input logic [7:0] p, input logic [7:0] d);
    int gap;
    cmd_ch.valid       <= 1'b1;
    cmd_ch.command     <= c;
    cmd_ch.slot        <= s;
    cmd_ch.period      <= p;
    cmd_ch.first_delay <= d;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    commands_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain_results();
    cmd_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic send_random();
    logic [2:0] c;
    logic [3:0] s;
    logic [7:0] p;
    logic [7:0] d;
    int         r;
    r = $urandom_range(0, 99);
    if (r < 40) c = CMD_TICK;
    else if (r < 62) c = CMD_CREATE;
    else if (r < 74) c = CMD_DELETE;
    else if (r < 85) c = CMD_SUSPEND;
    else if (r < 96) c = CMD_RESUME;
    else c = 3'($urandom_range(5, 7));
    s = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(SLOTS, 15))
                                    : 4'($urandom_range(0, SLOTS - 1));
    // short periods keep tasks firing often
    p = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    d = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
    if (c == CMD_TICK) begin
      s = 4'($urandom);
      p = 8'($urandom);
      d = 8'($urandom);
    end
    send_item(c, s, p, d);
  endtask

  // result side: random stalls plus one long hold-off while commands keep coming
  initial begin
    int stall;
    res_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!hold_off_done && commands_sent >= 60) begin
        hold_off_done = 1'b1;
        res_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      stall = pick_gap();
      if (stall > 0) begin
        res_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  end

  initial begin
    int counted;
    rst                <= 1'b1;
    cmd_ch.valid       <= 1'b0;
    cmd_ch.command     <= CMD_TICK;
    cmd_ch.slot        <= 4'd0;
    cmd_ch.period      <= 8'd0;
    cmd_ch.first_delay <= 8'd0;
    commands_sent = 0;
    quiet         = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed: status codes, suspend and resume, ignored command, all slots due at once
    send_item(CMD_CREATE, 4'd0, 8'd0, 8'd0);
    send_item(CMD_CREATE, 4'd0, 8'd3, 8'd3);
    send_item(CMD_CREATE, 4'(SLOTS), 8'd1, 8'd1);
    send_item(CMD_CREATE, 4'd15, 8'd255, 8'd255);
    send_item(CMD_DELETE, 4'd3, 8'd0, 8'd0);
    send_item(CMD_SUSPEND, 4'd3, 8'd0, 8'd0);
    send_item(CMD_RESUME, 4'd3, 8'd0, 8'd0);
    send_item(CMD_DELETE, 4'd15, 8'd0, 8'd0);
    send_item(CMD_CREATE, 4'(SLOTS - 1), 8'd255, 8'd255);
    send_item(CMD_TICK, 4'd0, 8'd0, 8'd0);
    send_item(CMD_SUSPEND, 4'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 4'd0, 8'd0, 8'd0);
    send_item(CMD_RESUME, 4'd0, 8'd0, 8'd0);
    send_item(3'd7, 4'd15, 8'd255, 8'd255);
    send_item(CMD_DELETE, 4'(SLOTS - 1), 8'd0, 8'd0);
    for (int i = 1; i < SLOTS - 1; i++) send_item(CMD_CREATE, 4'(i), 8'd0, 8'd0);
    send_item(CMD_CREATE, 4'(SLOTS - 1), 8'd1, 8'd0);
    send_item(CMD_TICK, 4'd0, 8'd0, 8'd0);
    send_item(CMD_TICK, 4'd0, 8'd0, 8'd0);
    drain_results();

    counted = 0;
    while (counted < 236) begin
      if (counted % 30 == 0) quiet = ($urandom_range(0, 3) == 0);
      if (counted == 150) drain_results();
      send_random();
      counted++;
    end

    drain_results();
    repeat (4 * SLOTS + 20) @(posedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("periodic_task_tick_scheduler: match");
    end else begin
      $display("periodic_task_tick_scheduler: mismatch");
    end
    $finish;
  end

  initial begin
    #6_000_000;
    $display("periodic_task_tick_scheduler: mismatch");
    $finish;
  end

endmodule
